[rtl/brs_pkg.sv]
// Package for the byte stream reassembler.
// Item and result structs, window width and the default ring depth.
// No dependencies.
`timescale 1ns / 1ps

package brs_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int WIN_W          = 7;

    typedef struct packed {
        logic        kind;          // 0 data byte, 1 end marker
        logic [31:0] byte_index;
        logic [7:0]  byte_value;
        logic        ends_stream;
    } t_item;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic             last;
        logic             stream_done;
        logic [WIN_W-1:0] pending_count;
    } t_result;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

endpackage

[rtl/byte_stream_reassembler_top.sv]
// Byte stream reassembler top level: admission, end tracking and in-order release.
// Depends on brs_pkg and brs_ram.
`timescale 1ns / 1ps

// An item is taken when i_start is high and o_busy is low. Each item goes
// through capture, then admission and store into the byte ring, then the
// release walk, which reads the ring one entry per cycle through its single
// read port and stops at the first entry that cannot be released.
// Every item produces at least one result; results leave on o_result, one per
// cycle while o_res_valid is high, and the receiver cannot stall them. The
// window register may be written at any time the block is idle (o_cfg_ready
// is always high). Valid marks clear at reset; no clearing pass is needed.
module byte_stream_reassembler_top #(
    parameter int RING_DEPTH = brs_pkg::RING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  brs_pkg::t_item              i_item,
    output logic                        o_res_valid,
    output brs_pkg::t_result            o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [brs_pkg::WIN_W-1:0]   i_cfg_data
);

    localparam int SW = $clog2(RING_DEPTH);
    localparam int WW = brs_pkg::WIN_W;
    localparam logic [WW-1:0] DEPTH_W    = WW'(RING_DEPTH);
    localparam logic [SW:0]   DEPTH_S    = (SW+1)'(RING_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_REL  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    brs_pkg::t_item        r_item, n_item;
    logic [31:0]           r_ne, n_ne;
    logic [SW-1:0]         r_ne_slot, n_ne_slot;
    logic                  r_end_known, n_end_known;
    logic [31:0]           r_end_pos, n_end_pos;
    logic [WW-1:0]         r_cnt, n_cnt;
    logic [RING_DEPTH-1:0] r_valid, n_valid;
    logic [WW-1:0]         r_window, n_window;
    logic                  r_out_pend, n_out_pend;
    logic                  r_snap_done, n_snap_done;
    logic [WW-1:0]         r_snap_cnt, n_snap_cnt;
    logic                  r_out_vld, n_out_vld;
    brs_pkg::t_result      r_out, n_out;

    logic [WW-1:0] w_eff;
    logic          ge_ne;
    logic [31:0]   diff;
    logic          above;
    logic          end_req;
    logic [31:0]   end_val;
    logic          rec;
    logic          end_known_new;
    logic [31:0]   end_pos_new;
    logic          store_ok;
    logic [SW:0]   slot_sum;
    logic [SW:0]   slot_mod;
    logic [SW-1:0] st_slot;
    logic          do_store;
    logic          can_rel;
    logic [31:0]   ne_inc;
    logic [SW-1:0] slot_inc;
    logic [7:0]    rd_data;
    logic          ram_we;

    brs_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (SW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (st_slot),
        .i_wdata (r_item.byte_value),
        .i_raddr (r_ne_slot),
        .o_rdata (rd_data)
    );

    // admission of the captured item
    always_comb begin
        if (r_window == '0) begin
            w_eff = WW'(1);
        end else if (r_window > DEPTH_W) begin
            w_eff = DEPTH_W;
        end else begin
            w_eff = r_window;
        end
        ge_ne = r_item.byte_index >= r_ne;
        diff  = r_item.byte_index - r_ne;
        above = ge_ne && (diff >= {{(32-WW){1'b0}}, w_eff});

        if (r_item.kind == brs_pkg::KIND_END) begin
            end_req = 1'b1;
            end_val = r_item.byte_index;
        end else begin
            // end index of the byte at the top index is not representable
            end_req = r_item.ends_stream && (r_item.byte_index != 32'hFFFF_FFFF);
            end_val = r_item.byte_index + 32'd1;
        end
        rec           = !above && end_req && !r_end_known;
        end_known_new = r_end_known | rec;
        end_pos_new   = rec ? ((end_val < r_ne) ? r_ne : end_val) : r_end_pos;

        store_ok = !above && (r_item.kind == brs_pkg::KIND_DATA) && ge_ne
                   && !(end_known_new && (r_item.byte_index >= end_pos_new));

        // slot = (slot of next expected + offset) mod depth; offset < depth
        slot_sum = {1'b0, r_ne_slot} + {1'b0, diff[SW-1:0]};
        slot_mod = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
        st_slot  = slot_mod[SW-1:0];
        do_store = store_ok && !r_valid[st_slot];
    end

    // release walk
    always_comb begin
        can_rel = r_valid[r_ne_slot] && !(r_end_known && (r_ne >= r_end_pos));
        ne_inc  = r_ne + 32'd1;
        if (r_ne == 32'hFFFF_FFFF || r_ne_slot == LAST_SLOT) begin
            slot_inc = '0;
        end else begin
            slot_inc = r_ne_slot + SW'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_ne        = r_ne;
        n_ne_slot   = r_ne_slot;
        n_end_known = r_end_known;
        n_end_pos   = r_end_pos;
        n_cnt       = r_cnt;
        n_valid     = r_valid;
        n_window    = r_window;
        n_out_pend  = r_out_pend;
        n_snap_done = r_snap_done;
        n_snap_cnt  = r_snap_cnt;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;

        if (i_cfg_valid) begin
            n_window = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_end_known = end_known_new;
                n_end_pos   = end_pos_new;
                if (do_store) begin
                    n_valid[st_slot] = 1'b1;
                    n_cnt            = r_cnt + WW'(1);
                    ram_we           = 1'b1;
                end
                n_out_pend = 1'b0;
                n_state    = S_REL;
            end
            S_REL: begin
                if (can_rel) begin
                    n_valid[r_ne_slot] = 1'b0;
                    n_ne               = ne_inc;
                    n_ne_slot          = slot_inc;
                    n_cnt              = r_cnt - WW'(1);
                    n_out_pend         = 1'b1;
                    n_snap_done        = r_end_known && (ne_inc == r_end_pos);
                    n_snap_cnt         = r_cnt - WW'(1);
                end else begin
                    n_out_pend = 1'b0;
                    n_state    = S_IDLE;
                end
                // byte read last cycle goes out now; last is known once the next check fails
                if (r_out_pend) begin
                    n_out_vld           = 1'b1;
                    n_out.has_byte      = 1'b1;
                    n_out.out_byte      = rd_data;
                    n_out.last          = !can_rel;
                    n_out.stream_done   = r_snap_done;
                    n_out.pending_count = r_snap_cnt;
                end else if (!can_rel) begin
                    n_out_vld           = 1'b1;
                    n_out.has_byte      = 1'b0;
                    n_out.out_byte      = 8'd0;
                    n_out.last          = 1'b1;
                    n_out.stream_done   = r_end_known && (r_ne == r_end_pos);
                    n_out.pending_count = r_cnt;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ne        <= '0;
            r_ne_slot   <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_window    <= WW'(64);
            r_out_pend  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ne        <= n_ne;
            r_ne_slot   <= n_ne_slot;
            r_end_known <= n_end_known;
            r_end_pos   <= n_end_pos;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
            r_window    <= n_window;
            r_out_pend  <= n_out_pend;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_snap_done <= n_snap_done;
        r_snap_cnt  <= n_snap_cnt;
        r_out       <= n_out;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/brs_ram.sv]
// Byte ring storage: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module brs_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[test/byte_stream_reassembler_top_tb.sv]
// Self-checking testbench for byte_stream_reassembler_top: in-window bytes, duplicates,
// window settings and end-of-stream handling, checked against a behavioral reassembler.
// Depends on brs_pkg and the byte_stream_reassembler_top RTL.
`timescale 1ns / 1ps

module byte_stream_reassembler_top_tb;

    localparam int DEPTH       = brs_pkg::RING_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    brs_pkg::t_item           i_item;
    logic                     o_res_valid;
    brs_pkg::t_result         o_result;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [brs_pkg::WIN_W-1:0] i_cfg_data;

    byte_stream_reassembler_top #(
        .RING_DEPTH (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // reassembler state as the block should hold it
    logic [7:0]                ring_copy [DEPTH];
    bit                        held [DEPTH];
    bit [31:0]                 next_exp   = '0;
    bit                        end_known  = 1'b0;
    bit [31:0]                 end_pos    = '0;
    int                        held_count = 0;
    bit [brs_pkg::WIN_W-1:0]   window_reg = 7'd64;

    brs_pkg::t_item            pending_items [$];
    brs_pkg::t_result          expected_results [$];
    int                        errors       = 0;
    int                        cycle_count  = 0;
    int                        queued_count = 0;
    bit                        item_taken   = 1'b0;
    int                        burst_left   = 1;
    int                        gap_left     = 0;

    // stimulus plan: next stream index to be covered and the effective window
    bit [31:0]        plan_next = '0;
    int               plan_win  = 64;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic string show(brs_pkg::t_result r);
        return $sformatf("has_byte=%0d out_byte=%02h last=%0d stream_done=%0d pending_count=%0d",
                         r.has_byte, r.out_byte, r.last, r.stream_done, r.pending_count);
    endfunction

    function automatic void note_end(bit [31:0] e);
        if (!end_known) begin
            end_known = 1'b1;
            end_pos   = (e < next_exp) ? next_exp : e;
        end
    endfunction

    // Admit one item, release the in-order run and queue the results it causes.
    function automatic void reassemble(brs_pkg::t_item it);
        brs_pkg::t_result run [$];
        brs_pkg::t_result r;
        bit [31:0]        idx;
        int unsigned      eff;
        int               slot;
        idx = it.byte_index;
        eff = (window_reg == 0) ? 1 : ((window_reg > DEPTH) ? DEPTH : window_reg);
        if (!(idx >= next_exp && (idx - next_exp) >= eff)) begin
            if (it.kind == brs_pkg::KIND_END) begin
                note_end(idx);
            end else begin
                if (it.ends_stream && idx != 32'hFFFF_FFFF) note_end(idx + 32'd1);
                if (idx >= next_exp && !(end_known && idx >= end_pos)) begin
                    slot = idx % DEPTH;
                    if (!held[slot]) begin
                        held[slot]      = 1'b1;
                        ring_copy[slot] = it.byte_value;
                        held_count++;
                    end
                end
            end
            while (run.size() < DEPTH) begin
                slot = next_exp % DEPTH;
                if (!held[slot] || (end_known && next_exp >= end_pos)) break;
                held[slot] = 1'b0;
                held_count--;
                next_exp++;
                r.has_byte      = 1'b1;
                r.out_byte      = ring_copy[slot];
                r.last          = 1'b0;
                r.stream_done   = end_known && next_exp == end_pos;
                r.pending_count = brs_pkg::WIN_W'(held_count);
                run.push_back(r);
            end
        end
        if (run.size() == 0) begin
            r.has_byte      = 1'b0;
            r.out_byte      = 8'h00;
            r.last          = 1'b0;
            r.stream_done   = end_known && next_exp == end_pos;
            r.pending_count = brs_pkg::WIN_W'(held_count);
            run.push_back(r);
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[k]) expected_results.push_back(run[k]);
    endfunction

    // monitor: check results, track register writes, predict accepted items
    always @(posedge i_clk) begin
        brs_pkg::t_result want;
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: %s", $time, show(o_result));
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.has_byte !== want.has_byte || o_result.out_byte !== want.out_byte
                        || o_result.last !== want.last || o_result.stream_done !== want.stream_done
                        || o_result.pending_count !== want.pending_count) begin
                        errors++;
                        $display("%0t: result mismatch", $time);
                        $display("    expected %s", show(want));
                        $display("    actual   %s", show(o_result));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) window_reg = i_cfg_data;
            if (i_start && !o_busy) reassemble(i_item);
        end
        item_taken <= i_rst_n && i_start && !o_busy;
    end

    // driver: bursts of items with random gaps between them
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || item_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start  <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item  <= pending_items.pop_front();
                i_start <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 16);
                    if ($urandom_range(0, 1) == 0) begin
                        gap_left <= 0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        gap_left <= $urandom_range(10, 40);
                    end else begin
                        gap_left <= $urandom_range(1, 6);
                    end
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_item(logic kind, bit [31:0] idx, bit [7:0] val, bit ends);
        brs_pkg::t_item it;
        it.kind        = kind;
        it.byte_index  = idx;
        it.byte_value  = val;
        it.ends_stream = ends;
        pending_items.push_back(it);
        queued_count++;
    endfunction

    // far above any window, so the block must ignore it, ends_stream included
    function automatic void add_noise();
        bit [31:0] idx;
        idx = $urandom();
        if (idx < plan_next + 32'd256) idx = idx + 32'h8000_0000;
        add_item($urandom_range(0, 1) ? brs_pkg::KIND_END : brs_pkg::KIND_DATA, idx,
                 rand_byte(), 1'($urandom_range(0, 1)));
    endfunction

    // Covers stream indices plan_next .. plan_next+len-1, mostly shuffled, with
    // duplicates, late bytes and noise mixed in.
    function automatic void add_chunk(int len);
        int order [$];
        int j;
        int tmp;
        for (int k = 0; k < len; k++) order.push_back(k);
        if ($urandom_range(0, 3) != 0) begin
            for (int k = len - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        end
        foreach (order[k]) begin
            case ($urandom_range(0, 9))
                0: add_noise();
                1: add_item(brs_pkg::KIND_DATA, plan_next + $urandom_range(0, len - 1),
                            rand_byte(), 1'b0);
                2: begin
                    if (plan_next > 0)
                        add_item(brs_pkg::KIND_DATA,
                                 plan_next - $urandom_range(1, (plan_next > 64) ? 64 : plan_next),
                                 rand_byte(), 1'b0);
                end
                default: ;
            endcase
            add_item(brs_pkg::KIND_DATA, plan_next + order[k], rand_byte(), 1'b0);
        end
        plan_next += len;
    endfunction

    function automatic void run_phase(int n);
        int stop;
        stop = queued_count + n;
        while (queued_count < stop) add_chunk($urandom_range(1, (plan_win < 12) ? plan_win : 12));
    endfunction

    // wait until every item is in and every result is out, then let the block go idle
    task automatic settle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_start || expected_results.size() != 0 || o_busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_window(bit [brs_pkg::WIN_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        plan_win = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : v);
    endtask

    initial begin
        int        win_list [5];
        bit [31:0] p;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        win_list    = '{0, 1, 127, 65, 0};
        win_list[4] = $urandom_range(2, 63);

        // directed opening, window at its reset value
        add_item(brs_pkg::KIND_DATA, 32'd0, 8'hFF, 1'b0);
        add_item(brs_pkg::KIND_DATA, 32'd0, 8'h00, 1'b0);     // below expected
        add_item(brs_pkg::KIND_DATA, 32'd3, 8'h00, 1'b0);
        add_item(brs_pkg::KIND_DATA, 32'd3, 8'hAA, 1'b0);     // duplicate, first value kept
        add_item(brs_pkg::KIND_DATA, 32'd2, 8'h55, 1'b0);
        add_item(brs_pkg::KIND_DATA, 32'd1, 8'h80, 1'b0);     // fills the gap, releases 1..3
        add_item(brs_pkg::KIND_DATA, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        add_item(brs_pkg::KIND_END, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        add_item(brs_pkg::KIND_DATA, 32'd68, 8'h7F, 1'b1);    // first index past the window
        add_item(brs_pkg::KIND_DATA, 32'd67, 8'h01, 1'b0);    // last index inside it
        add_item(brs_pkg::KIND_END, 32'h8000_0000, 8'h00, 1'b0);
        add_item(brs_pkg::KIND_DATA, 32'd4, 8'hC3, 1'b0);
        plan_next = 32'd5;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        run_phase(35);
        settle();
        foreach (win_list[k]) begin
            write_window(brs_pkg::WIN_W'(win_list[k]));
            run_phase(35);
            settle();
        end

        // full window held back, then one byte releases all of it
        write_window(brs_pkg::WIN_W'(64));
        p = plan_next;
        for (int k = 63; k >= 1; k--) add_item(brs_pkg::KIND_DATA, p + k, rand_byte(), 1'b0);
        add_item(brs_pkg::KIND_DATA, p, rand_byte(), 1'b0);
        plan_next += 64;
        run_phase(20);
        settle();

        // the stream ends once per run; pick how
        p = plan_next;
        case ($urandom_range(0, 3))
            0: begin
                // bytes stored past the end stay counted
                add_item(brs_pkg::KIND_DATA, p + 2, rand_byte(), 1'b0);
                add_item(brs_pkg::KIND_DATA, p + 4, rand_byte(), 1'b0);
                add_item(brs_pkg::KIND_DATA, p + 5, rand_byte(), 1'b0);
                add_item(brs_pkg::KIND_END, p + 3, rand_byte(), 1'b0);
                add_item(brs_pkg::KIND_DATA, p, rand_byte(), 1'b0);
                add_item(brs_pkg::KIND_DATA, p + 1, rand_byte(), 1'b0);
            end
            1: begin
                add_item(brs_pkg::KIND_DATA, p + 1, rand_byte(), 1'b1);
                add_item(brs_pkg::KIND_DATA, p, rand_byte(), 1'b0);
            end
            2: add_item(brs_pkg::KIND_END, p - 5, rand_byte(), 1'b0);   // raised to next expected
            default: add_item(brs_pkg::KIND_DATA, p - 1, rand_byte(), 1'b1);
        endcase
        // later ends are ignored, bytes at or past the end dropped
        add_item(brs_pkg::KIND_DATA, p + 6, rand_byte(), 1'b1);
        add_item(brs_pkg::KIND_END, p + 7, rand_byte(), 1'b0);
        add_item(brs_pkg::KIND_DATA, p + 2, rand_byte(), 1'b0);
        add_item(brs_pkg::KIND_DATA, p - 2, rand_byte(), 1'b1);
        add_item(brs_pkg::KIND_DATA, p + 3, rand_byte(), 1'b0);
        for (int k = 0; k < 4; k++) add_noise();
        add_item(brs_pkg::KIND_DATA, 32'hFFFF_FFFF, 8'h00, 1'b1);
        settle();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[byte_stream_reassembler_top.f]
rtl/brs_pkg.sv
rtl/brs_ram.sv
rtl/byte_stream_reassembler_top.sv
test/byte_stream_reassembler_top_tb.sv
